@@ src/srt_pkg.sv @@
// Shared types and codes for the SACK range table.
package srt_pkg;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DISCARD = 2'd1,
        OP_QUERY   = 2'd2,
        OP_STATUS  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_TAIL,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
        logic tail;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } sts_t;

endpackage

@@ src/srt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module srt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/srt_ctrl.sv @@
// Sequencer that walks the block table once per request.
module srt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  srt_pkg::sts_t sts,
    output srt_pkg::cmd_t cmd
);

    srt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            srt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = srt_pkg::ST_FETCH;
                end
            end
            srt_pkg::ST_FETCH:
            begin
                state_next = sts.scan_done ? srt_pkg::ST_TAIL : srt_pkg::ST_EVAL;
            end
            srt_pkg::ST_EVAL:
            begin
                cmd.step   = 1'b1;
                state_next = srt_pkg::ST_FETCH;
            end
            srt_pkg::ST_TAIL:
            begin
                cmd.tail   = 1'b1;
                state_next = srt_pkg::ST_FIN;
            end
            srt_pkg::ST_FIN:
            begin
                // hold until the previous result has been taken
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = srt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/srt_dp.sv @@
// Datapath: two table banks, merge/trim logic, result registers.
module srt_dp #(
    parameter int MAX_BLOCKS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  srt_pkg::cmd_t cmd,
    output srt_pkg::sts_t sts,
    input  logic [1:0]    command,
    input  logic [31:0]   seq,
    input  logic [31:0]   length,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          contained,
    output logic [31:0]   removed_bytes,
    output logic          front_valid,
    output logic [31:0]   front_start,
    output logic [31:0]   front_len,
    output logic [31:0]   held_bytes,
    output logic [4:0]    block_count,
    output logic          overflow
);

    localparam int AW  = $clog2(MAX_BLOCKS);
    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int WCW = $clog2(MAX_BLOCKS + 2);
    localparam logic [32:0] SeqTop = 33'h0_FFFF_FFFF;

    logic [1:0]     cmd_reg;
    logic [31:0]    s_reg, s_next;
    logic [32:0]    e_reg, e_next;
    logic           act_reg, act_next;
    logic           bank_reg;
    logic [CW-1:0]  used_reg;
    logic [CW-1:0]  rd_reg;
    logic [WCW-1:0] wr_reg;
    logic [31:0]    nstart_reg, nlen_reg, nsum_reg;
    logic [31:0]    ostart_reg, olen_reg, osum_reg;
    logic           cont_reg;
    logic [31:0]    rem_reg;

    logic [63:0] rdata0, rdata1, rdata;
    logic        we0, we1;
    logic [31:0] bs, bl;
    logic [32:0] be, ack33, sum33, sat33;

    logic        adv, emit_en, wr_en, ovf;
    logic [31:0] emit_s, emit_l, rem_add;
    logic        cont_hit;
    logic [CW+4:0]  cnt_ext;
    logic [CW-1:0]  fin_cnt;

    srt_ram #(.WIDTH(64), .DEPTH(MAX_BLOCKS)) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (wr_reg[AW-1:0]),
        .wdata ({emit_s, emit_l}),
        .raddr (rd_reg[AW-1:0]),
        .rdata (rdata0)
    );

    srt_ram #(.WIDTH(64), .DEPTH(MAX_BLOCKS)) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (wr_reg[AW-1:0]),
        .wdata ({emit_s, emit_l}),
        .raddr (rd_reg[AW-1:0]),
        .rdata (rdata1)
    );

    assign rdata = bank_reg ? rdata1 : rdata0;
    assign bs    = rdata[63:32];
    assign bl    = rdata[31:0];
    assign be    = {1'b0, bs} + {1'b0, bl};
    assign ack33 = {1'b0, s_reg};
    assign sum33 = {1'b0, seq} + {1'b0, length};
    assign sat33 = (sum33 > SeqTop) ? SeqTop : sum33;

    assign sts.scan_done = (rd_reg == used_reg);
    assign sts.out_busy  = out_valid && !out_ready;

    // scan step: decide what the current old block turns into
    always_comb
    begin
        adv      = 1'b1;
        emit_en  = 1'b0;
        emit_s   = bs;
        emit_l   = bl;
        s_next   = s_reg;
        e_next   = e_reg;
        act_next = act_reg;
        rem_add  = '0;
        cont_hit = 1'b0;
        if (cmd.step)
        begin
            case (cmd_reg)
                srt_pkg::OP_INSERT:
                begin
                    if (!act_reg || be < {1'b0, s_reg})
                    begin
                        emit_en = 1'b1;
                    end
                    else if ({1'b0, bs} > e_reg)
                    begin
                        // place the new range first, revisit this block
                        emit_en  = 1'b1;
                        emit_s   = s_reg;
                        emit_l   = 32'(e_reg - {1'b0, s_reg});
                        act_next = 1'b0;
                        adv      = 1'b0;
                    end
                    else
                    begin
                        s_next = (bs < s_reg) ? bs : s_reg;
                        e_next = (be > e_reg) ? be : e_reg;
                    end
                end
                srt_pkg::OP_DISCARD:
                begin
                    if (be <= ack33)
                    begin
                        rem_add = bl;
                    end
                    else if (bs < s_reg)
                    begin
                        rem_add = s_reg - bs;
                        emit_en = 1'b1;
                        emit_s  = s_reg;
                        emit_l  = 32'(be - ack33);
                    end
                    else
                    begin
                        emit_en = 1'b1;
                    end
                end
                default:
                begin
                    emit_en  = 1'b1;
                    cont_hit = (cmd_reg == srt_pkg::OP_QUERY) && (bs <= s_reg) && (e_reg <= be);
                end
            endcase
        end
        else if (cmd.tail && cmd_reg == srt_pkg::OP_INSERT && act_reg)
        begin
            emit_en  = 1'b1;
            emit_s   = s_reg;
            emit_l   = 32'(e_reg - {1'b0, s_reg});
            act_next = 1'b0;
        end
    end

    assign wr_en = emit_en && (wr_reg < WCW'(MAX_BLOCKS));
    assign we0   = wr_en && bank_reg;
    assign we1   = wr_en && !bank_reg;
    assign ovf   = (wr_reg > WCW'(MAX_BLOCKS));
    assign fin_cnt = ovf ? used_reg : wr_reg[CW-1:0];
    assign cnt_ext = {5'd0, fin_cnt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= 1'b0;
            used_reg  <= '0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            act_reg   <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            if (cmd.start)
            begin
                rd_reg  <= '0;
                wr_reg  <= '0;
                act_reg <= (command == srt_pkg::OP_INSERT) && (sat33 > {1'b0, seq});
            end
            else
            begin
                act_reg <= act_next;
                if (cmd.step && adv)
                begin
                    rd_reg <= rd_reg + CW'(1);
                end
                if (emit_en)
                begin
                    wr_reg <= wr_reg + WCW'(1);
                end
            end
            if (cmd.finish)
            begin
                out_valid <= 1'b1;
                if (!ovf)
                begin
                    bank_reg <= !bank_reg;
                    used_reg <= wr_reg[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cmd_reg    <= command;
            s_reg      <= seq;
            e_reg      <= (command == srt_pkg::OP_INSERT) ? sat33 : sum33;
            nstart_reg <= '0;
            nlen_reg   <= '0;
            nsum_reg   <= '0;
            ostart_reg <= '0;
            olen_reg   <= '0;
            osum_reg   <= '0;
            cont_reg   <= 1'b0;
            rem_reg    <= '0;
        end
        else
        begin
            s_reg <= s_next;
            e_reg <= e_next;
            if (cmd.step && adv)
            begin
                osum_reg <= osum_reg + bl;
                rem_reg  <= rem_reg + rem_add;
                if (cont_hit)
                begin
                    cont_reg <= 1'b1;
                end
                if (rd_reg == '0)
                begin
                    ostart_reg <= bs;
                    olen_reg   <= bl;
                end
            end
            if (emit_en)
            begin
                nsum_reg <= nsum_reg + emit_l;
                if (wr_reg == '0)
                begin
                    nstart_reg <= emit_s;
                    nlen_reg   <= emit_l;
                end
            end
        end
        if (cmd.finish)
        begin
            contained     <= cont_reg;
            removed_bytes <= rem_reg;
            overflow      <= ovf;
            front_valid   <= (fin_cnt != '0);
            front_start   <= ovf ? ostart_reg : nstart_reg;
            front_len     <= ovf ? olen_reg : nlen_reg;
            held_bytes    <= ovf ? osum_reg : nsum_reg;
            block_count   <= cnt_ext[4:0];
        end
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_BLOCKS))
        else $error("block count above capacity");

    a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg <= WCW'(MAX_BLOCKS + 1))
        else $error("write count ran past one overflow slot");

    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && !ovf |=> used_reg == $past(wr_reg[CW-1:0]))
        else $error("table size not committed from write count");

    a_ovf_insert: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && ovf |-> cmd_reg == srt_pkg::OP_INSERT)
        else $error("overflow on a non-insert request");
`endif

endmodule

@@ src/sack_range_table.sv @@
// Top level of the SACK range table.
// Sorted table of up to MAX_BLOCKS disjoint SACK ranges with insert/merge,
// discard below a cumulative ack, containment query and status. Each request
// rewrites the table from one RAM bank into the other while walking it, each
// stored block taking a RAM read, then an evaluate step, plus one extra pass
// when an insert lands ahead of a block. One request is in flight at a
// time; a finished result waits in the output register while the next
// request is accepted. Table contents need no clearing after reset.
module sack_range_table #(
    parameter int MAX_BLOCKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] seq,
    input  logic [31:0] length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        contained,
    output logic [31:0] removed_bytes,
    output logic        front_valid,
    output logic [31:0] front_start,
    output logic [31:0] front_len,
    output logic [31:0] held_bytes,
    output logic [4:0]  block_count,
    output logic        overflow
);

    srt_pkg::cmd_t cmd;
    srt_pkg::sts_t sts;

    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srt_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .command       (command),
        .seq           (seq),
        .length        (length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .contained     (contained),
        .removed_bytes (removed_bytes),
        .front_valid   (front_valid),
        .front_start   (front_start),
        .front_len     (front_len),
        .held_bytes    (held_bytes),
        .block_count   (block_count),
        .overflow      (overflow)
    );

endmodule
